// ===== rtl/cesmh_pkg.sv =====
package cesmh_pkg;

    localparam int MAX_LEAVES    = 64;
    localparam int MAX_MUTATIONS = 64;
    localparam int EVENT_DEPTH   = MAX_LEAVES + MAX_MUTATIONS - 1;
    localparam int POP_DEPTH     = MAX_LEAVES - 1;
    localparam int EA_W          = $clog2(EVENT_DEPTH);
    localparam int PA_W          = $clog2(POP_DEPTH);

    localparam logic [1:0] KIND_WR_EVENT = 2'd0;
    localparam logic [1:0] KIND_WR_POP   = 2'd1;
    localparam logic [1:0] KIND_PROPOSE  = 2'd2;
    localparam logic [1:0] KIND_RD_EVENT = 2'd3;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_SWAPPED  = 3'd1;
    localparam logic [2:0] ST_UNCHANGED = 3'd2;
    localparam logic [2:0] ST_ACCEPTED = 3'd3;
    localparam logic [2:0] ST_REJECTED = 3'd4;
    localparam logic [2:0] ST_INVALID  = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  slot_index;
        logic [6:0]  genotype;
        logic [7:0]  produced_genotype;
        logic [6:0]  genotype_lineages;
        logic [6:0]  total_lineages;
        logic [31:0] population_size;
        logic [31:0] uniform_draw;
    } item_t;

    typedef struct packed {
        logic [6:0] genotype;
        logic [7:0] produced;
        logic [6:0] genotype_lineages;
        logic [6:0] total_lineages;
    } event_t;

endpackage

// ===== rtl/coalescent_event_swap_mh_step.sv =====
// Each item walks the states RD0, RD1 (propose beats only, for the second table
// read), DEC, POP, POPB, MULA, MULB, MUL, CMP, WR0, WR1 and OUT; OUT waits while
// the output is stalled. The executor serves one item at a time, so it takes no new
// item until the last has left OUT; its multiply chain runs for every item kind.
// A two-entry queue lets the next beat be accepted while an item executes.
// Reset clears control state and loads leaf_count=2, mutation_count=0,
// rooted_tree=1; the event and size tables are undefined until written.
module coalescent_event_swap_mh_step (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [6:0]  slot_index,
    input  logic [6:0]  genotype,
    input  logic signed [7:0] produced_genotype,
    input  logic [6:0]  genotype_lineages,
    input  logic [6:0]  total_lineages,
    input  logic [31:0] population_size,
    input  logic [31:0] uniform_draw,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [6:0]  read_genotype,
    output logic signed [7:0] read_produced,
    output logic [6:0]  read_genotype_lineages,
    output logic [6:0]  read_total_lineages
);
    import cesmh_pkg::*;

    localparam logic [1:0] CFG_LEAVES = 2'd0;
    localparam logic [1:0] CFG_MUTS   = 2'd1;
    localparam logic [1:0] CFG_ROOTED = 2'd2;

    logic [6:0] leaf_count_reg;
    logic [6:0] mutation_count_reg;
    logic       rooted_tree_reg;
    item_t      in_item;
    item_t      q_item;
    logic       q_valid;
    logic       q_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_count_reg     <= 7'd2;
            mutation_count_reg <= 7'd0;
            rooted_tree_reg    <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LEAVES: leaf_count_reg     <= cfg_data;
                CFG_MUTS:   mutation_count_reg <= cfg_data;
                CFG_ROOTED: rooted_tree_reg    <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    assign in_item = '{kind, slot_index, genotype, produced_genotype,
                       genotype_lineages, total_lineages, population_size, uniform_draw};

    cesmh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_take  (q_take),
        .out_item  (q_item)
    );

    cesmh_exec u_exec (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .leaf_count             (leaf_count_reg),
        .mutation_count         (mutation_count_reg),
        .rooted_tree            (rooted_tree_reg),
        .item_valid             (q_valid),
        .item_take              (q_take),
        .item                   (q_item),
        .valid                  (out_valid),
        .stall                  (out_stall),
        .status                 (status),
        .read_genotype          (read_genotype),
        .read_produced          (read_produced),
        .read_genotype_lineages (read_genotype_lineages),
        .read_total_lineages    (read_total_lineages)
    );
endmodule

// ===== rtl/cesmh_queue.sv =====
module cesmh_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  cesmh_pkg::item_t     in_item,
    output logic                 out_valid,
    input  logic                 out_take,
    output cesmh_pkg::item_t     out_item
);
    import cesmh_pkg::*;

    item_t      mem_reg [2];
    logic [1:0] count_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       push;
    logic       pop;

    assign in_stall  = (count_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_take;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== rtl/cesmh_exec.sv =====
module cesmh_exec (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [6:0]           leaf_count,
    input  logic [6:0]           mutation_count,
    input  logic                 rooted_tree,
    input  logic                 item_valid,
    output logic                 item_take,
    input  cesmh_pkg::item_t     item,
    output logic                 valid,
    input  logic                 stall,
    output logic [2:0]           status,
    output logic [6:0]           read_genotype,
    output logic signed [7:0]    read_produced,
    output logic [6:0]           read_genotype_lineages,
    output logic [6:0]           read_total_lineages
);
    import cesmh_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_POP   = 4'd4;
    localparam logic [3:0] S_MULA  = 4'd5;
    localparam logic [3:0] S_MULB  = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_WR0   = 4'd8;
    localparam logic [3:0] S_WR1   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_POPB  = 4'd11;
    localparam logic [3:0] S_MUL   = 4'd12;

    event_t        ev_mem [EVENT_DEPTH];
    logic [31:0]   pop_mem [POP_DEPTH];

    logic [3:0]    state_reg, state_next;
    item_t         it_reg;
    event_t        e0_reg, e1_reg, rd_reg;
    event_t        w0_reg, w1_reg;
    logic [31:0]   nc_reg, np_reg, fa_reg, fb_reg;
    logic [6:0]    ck_reg, pk_reg;
    logic [2:0]    st_reg;
    logic [159:0]  lhs_reg, rhs_reg;
    logic [1:0]    mstep_reg;
    logic [2:0]    limb_reg;
    logic [31:0]   lcarry_reg, rcarry_reg;
    logic          out_valid_reg;
    logic [2:0]    out_status_reg;
    event_t        out_ev_reg;
    logic          decide_mh_reg;
    logic          do_write_reg;

    logic [EA_W-1:0] ra_addr;
    logic [EA_W-1:0] wa_addr;
    logic            we;
    event_t          wdata;
    logic [PA_W-1:0] pa_addr;

    logic [7:0]  nm;
    logic [7:0]  last_i;
    logic signed [7:0] pi, pj;
    logic [6:0]  gi, gj;

    assign valid                  = out_valid_reg;
    assign status                 = out_status_reg;
    assign read_genotype          = out_ev_reg.genotype;
    assign read_produced          = out_ev_reg.produced;
    assign read_genotype_lineages = out_ev_reg.genotype_lineages;
    assign read_total_lineages    = out_ev_reg.total_lineages;

    assign item_take = (state_reg == S_IDLE) && item_valid;

    assign nm     = {1'b0, leaf_count} + {1'b0, mutation_count};
    assign last_i = nm - 8'd3;
    assign gi = e0_reg.genotype;
    assign gj = e1_reg.genotype;
    assign pi = e0_reg.produced;
    assign pj = e1_reg.produced;

    always_ff @(posedge clk)
    begin
        rd_reg <= ev_mem[ra_addr];
        if (we)
        begin
            ev_mem[wa_addr] <= wdata;
        end
    end

    logic [31:0] pop_rd_reg;
    logic        pop_we;
    always_ff @(posedge clk)
    begin
        pop_rd_reg <= pop_mem[pa_addr];
        if (pop_we)
        begin
            pop_mem[pa_addr] <= it_reg.population_size;
        end
    end

    always_comb
    begin
        ra_addr = it_reg.slot_index[EA_W-1:0];
        if (state_reg == S_RD1)
        begin
            ra_addr = EA_W'(it_reg.slot_index + 7'd1);
        end
        we      = 1'b0;
        wa_addr = it_reg.slot_index[EA_W-1:0];
        wdata   = w0_reg;
        if (state_reg == S_WR0)
        begin
            we = do_write_reg;
        end
        else if (state_reg == S_WR1)
        begin
            we      = do_write_reg && (it_reg.kind == KIND_PROPOSE);
            wa_addr = EA_W'(it_reg.slot_index + 7'd1);
            wdata   = w1_reg;
        end
        pop_we  = 1'b0;
        pa_addr = it_reg.slot_index[PA_W-1:0];
        if (state_reg == S_POP)
        begin
            pa_addr = PA_W'(leaf_count - e1_reg.total_lineages);
        end
        else if (state_reg == S_POPB)
        begin
            pa_addr = PA_W'(leaf_count - pk_reg);
        end
        else if (state_reg == S_RD0 && it_reg.kind == KIND_WR_POP
                 && it_reg.slot_index < 7'(POP_DEPTH)
                 && it_reg.population_size != 32'd0)
        begin
            pop_we = 1'b1;
        end
    end

    logic [6:0] ng0, ng1;
    assign ng0 = e0_reg.genotype_lineages;
    assign ng1 = e1_reg.genotype_lineages;

    logic [13:0] pc2, cc2;
    logic [39:0] lbase, rbase;
    logic [7:0]  limb_pos;
    logic [31:0] lfac, rfac;
    logic [63:0] lprod, rprod;

    always_comb
    begin
        pc2   = 14'({7'd0, pk_reg} * {7'd0, pk_reg - 7'd1}) >> 1;
        cc2   = 14'({7'd0, ck_reg} * {7'd0, ck_reg - 7'd1}) >> 1;
        lbase = 40'(pk_reg) * 40'(np_reg) + 40'({pc2, 16'd0});
        rbase = 40'(ck_reg) * 40'(nc_reg) + 40'({cc2, 16'd0});
        limb_pos = {limb_reg, 5'd0};
        case (mstep_reg)
            2'd0:    lfac = nc_reg;
            2'd1:    lfac = fb_reg;
            default: lfac = it_reg.uniform_draw;
        endcase
        rfac  = (mstep_reg == 2'd0) ? np_reg : fa_reg;
        lprod = 64'(lhs_reg[limb_pos +: 32]) * 64'(lfac) + 64'(lcarry_reg);
        rprod = 64'(rhs_reg[limb_pos +: 32]) * 64'(rfac) + 64'(rcarry_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (item_valid) state_next = S_RD0;
            S_RD0:  state_next = (it_reg.kind == KIND_PROPOSE) ? S_RD1 : S_DEC;
            S_RD1:  state_next = S_DEC;
            S_DEC:  state_next = S_POP;
            S_POP:  state_next = S_POPB;
            S_POPB: state_next = S_MULA;
            S_MULA: state_next = S_MULB;
            S_MULB: state_next = S_MUL;
            S_MUL:  if (limb_reg == 3'd4 && mstep_reg == 2'd2) state_next = S_CMP;
            S_CMP:  state_next = S_WR0;
            S_WR0:  state_next = S_WR1;
            S_WR1:  state_next = S_OUT;
            S_OUT:  if (!out_valid_reg || !stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                it_reg <= item;
            end
            S_RD0:
            begin
                st_reg       <= ST_DONE;
                decide_mh_reg <= 1'b0;
                do_write_reg <= 1'b0;
                mstep_reg    <= 2'd0;
            end
            S_RD1:
            begin
                e0_reg <= rd_reg;
            end
            S_DEC:
            begin
                if (it_reg.kind == KIND_PROPOSE)
                begin
                    e1_reg <= rd_reg;
                end
                else
                begin
                    e0_reg <= rd_reg;
                end
            end
            S_POP:
            begin
                case (it_reg.kind)
                    KIND_WR_EVENT:
                    begin
                        if (it_reg.slot_index >= 7'(EVENT_DEPTH))
                        begin
                            st_reg <= ST_INVALID;
                        end
                        else
                        begin
                            do_write_reg <= 1'b1;
                            w0_reg <= '{it_reg.genotype, it_reg.produced_genotype,
                                        it_reg.genotype_lineages, it_reg.total_lineages};
                            w1_reg <= '{it_reg.genotype, it_reg.produced_genotype,
                                        it_reg.genotype_lineages, it_reg.total_lineages};
                        end
                    end
                    KIND_WR_POP:
                    begin
                        if (it_reg.slot_index >= 7'(POP_DEPTH)
                            || it_reg.population_size == 32'd0)
                        begin
                            st_reg <= ST_INVALID;
                        end
                    end
                    KIND_RD_EVENT:
                    begin
                        if (it_reg.slot_index >= 7'(EVENT_DEPTH))
                        begin
                            st_reg <= ST_INVALID;
                        end
                    end
                    default:
                    begin
                        w0_reg <= e1_reg;
                        w1_reg <= e0_reg;
                        fa_reg <= 32'd1;
                        fb_reg <= 32'd1;
                        if (leaf_count < 7'd2 || leaf_count > 7'(MAX_LEAVES)
                            || mutation_count > 7'(MAX_MUTATIONS)
                            || {1'b0, it_reg.slot_index} + 8'd1 >= nm - 8'd1
                            || nm < 8'd2)
                        begin
                            st_reg <= ST_INVALID;
                        end
                        else if (gi == gj)
                        begin
                            st_reg <= ST_UNCHANGED;
                        end
                        else if (pi == -8'sd1 && pj == -8'sd1)
                        begin
                            st_reg <= ST_SWAPPED;
                            do_write_reg <= 1'b1;
                            w0_reg <= '{gj, pi, ng1, e0_reg.total_lineages};
                            w1_reg <= '{gi, pj, ng0, e1_reg.total_lineages};
                        end
                        else if (pi != -8'sd1 && pj != -8'sd1 && pi != {1'b0, gj})
                        begin
                            st_reg <= ST_SWAPPED;
                            do_write_reg <= 1'b1;
                            w0_reg <= '{gj, pj, ng1, e0_reg.total_lineages};
                            w1_reg <= '{gi, pi, ng0, e1_reg.total_lineages};
                        end
                        else if ({1'b0, it_reg.slot_index} == last_i)
                        begin
                            if (rooted_tree)
                                st_reg <= ST_UNCHANGED;
                            else if (pj != -8'sd1)
                                st_reg <= ST_INVALID;
                            else if (pi == -8'sd1)
                                st_reg <= ST_UNCHANGED;
                            else
                            begin
                                st_reg <= ST_SWAPPED;
                                do_write_reg <= 1'b1;
                                w0_reg <= '{gj, {1'b0, gi}, ng0, e0_reg.total_lineages};
                                w1_reg <= '{gi, pj, ng1, e1_reg.total_lineages};
                            end
                        end
                        else if (pi == {1'b0, gj} && ng1 <= 7'd2)
                        begin
                            st_reg <= ST_UNCHANGED;
                        end
                        else if (pi == -8'sd1 && pj != -8'sd1)
                        begin
                            ck_reg <= e1_reg.total_lineages;
                            pk_reg <= e1_reg.total_lineages + 7'd1;
                            if (e1_reg.total_lineages < 7'd2
                                || e1_reg.total_lineages > leaf_count - 7'd1)
                                st_reg <= ST_INVALID;
                            else if (pj == {1'b0, gi} && ng0 < 7'd2)
                                st_reg <= ST_INVALID;
                            else
                            begin
                                decide_mh_reg <= 1'b1;
                                if (pj == {1'b0, gi})
                                begin
                                    fa_reg <= {25'd0, ng0} + 32'd1;
                                    fb_reg <= {25'd0, ng0} - 32'd1;
                                end
                                w0_reg <= '{gj, pj, ng1, e0_reg.total_lineages};
                                w1_reg <= '{gi, pi,
                                    (pj == {1'b0, gi} && ng0 < 7'd127) ? ng0 + 7'd1 : ng0,
                                    e1_reg.total_lineages + 7'd1};
                            end
                        end
                        else if (pi != -8'sd1 && pj == -8'sd1)
                        begin
                            ck_reg <= e1_reg.total_lineages;
                            pk_reg <= e1_reg.total_lineages - 7'd1;
                            if (e1_reg.total_lineages < 7'd3
                                || e1_reg.total_lineages > leaf_count)
                                st_reg <= ST_INVALID;
                            else if (pi == {1'b0, gj} && ng1 < 7'd3)
                                st_reg <= ST_INVALID;
                            else
                            begin
                                decide_mh_reg <= 1'b1;
                                if (pi == {1'b0, gj})
                                begin
                                    fa_reg <= {25'd0, ng1} - 32'd2;
                                    fb_reg <= {25'd0, ng1};
                                end
                                w0_reg <= '{gj, pj,
                                    (pi == {1'b0, gj}) ? ng1 - 7'd1 : ng1,
                                    e0_reg.total_lineages};
                                w1_reg <= '{gi, pi, ng0, e1_reg.total_lineages - 7'd1};
                            end
                        end
                        else
                        begin
                            st_reg <= ST_INVALID;
                        end
                    end
                endcase
            end
            S_POPB:
            begin
                nc_reg <= pop_rd_reg;
            end
            S_MULA:
            begin
                np_reg <= pop_rd_reg;
            end
            S_MULB:
            begin
                lhs_reg    <= 160'(lbase);
                rhs_reg    <= 160'(rbase);
                mstep_reg  <= 2'd0;
                limb_reg   <= 3'd0;
                lcarry_reg <= 32'd0;
                rcarry_reg <= 32'd0;
            end
            S_MUL:
            begin
                lhs_reg[limb_pos +: 32] <= lprod[31:0];
                if (mstep_reg != 2'd2)
                begin
                    rhs_reg[limb_pos +: 32] <= rprod[31:0];
                end
                if (limb_reg == 3'd4)
                begin
                    limb_reg   <= 3'd0;
                    mstep_reg  <= mstep_reg + 2'd1;
                    lcarry_reg <= 32'd0;
                    rcarry_reg <= 32'd0;
                end
                else
                begin
                    limb_reg   <= limb_reg + 3'd1;
                    lcarry_reg <= lprod[63:32];
                    if (mstep_reg != 2'd2)
                    begin
                        rcarry_reg <= rprod[63:32];
                    end
                end
            end
            S_CMP:
            begin
                if (decide_mh_reg)
                begin
                    if (lhs_reg < {rhs_reg[127:0], 32'd0})
                    begin
                        st_reg       <= ST_ACCEPTED;
                        do_write_reg <= 1'b1;
                    end
                    else
                    begin
                        st_reg <= ST_REJECTED;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !stall)
                begin
                    out_status_reg <= st_reg;
                    out_ev_reg <= (it_reg.kind == KIND_RD_EVENT && st_reg == ST_DONE)
                                  ? e0_reg : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== sim/testbench.sv =====
module testbench;
    import cesmh_pkg::*;

    localparam logic [1:0] REG_LEAVES    = 2'd0;
    localparam logic [1:0] REG_MUTATIONS = 2'd1;
    localparam logic [1:0] REG_ROOTED    = 2'd2;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [2:0] status;
        logic [6:0] genotype;
        logic [7:0] produced;
        logic [6:0] genotype_lineages;
        logic [6:0] total_lineages;
    } outcome_t;

    class swap_scoreboard;
        bit [6:0]  ev_geno [EVENT_DEPTH];
        bit [7:0]  ev_prod [EVENT_DEPTH];
        bit [6:0]  ev_glin [EVENT_DEPTH];
        bit [6:0]  ev_tlin [EVENT_DEPTH];
        bit [31:0] pop_size [POP_DEPTH];
        int leaves = 2;
        int mutations = 0;
        bit rooted = 1;
        outcome_t awaited[$];
        int errors = 0;

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void set_reg(logic [1:0] idx, logic [6:0] val);
            if (idx == REG_LEAVES)
                leaves = val;
            else if (idx == REG_MUTATIONS)
                mutations = val;
            else if (idx == REG_ROOTED)
                rooted = val[0];
        endfunction

        function void swap_pair(int i, bit do_prod);
            bit [7:0] t;
            t = ev_geno[i]; ev_geno[i] = ev_geno[i+1]; ev_geno[i+1] = t;
            t = ev_glin[i]; ev_glin[i] = ev_glin[i+1]; ev_glin[i+1] = t;
            if (do_prod)
            begin
                t = ev_prod[i]; ev_prod[i] = ev_prod[i+1]; ev_prod[i+1] = t;
            end
        endfunction

        function bit ratio_accepts(longint unsigned ck, longint unsigned pk,
                                   bit [31:0] nc, bit [31:0] np,
                                   int fa, int fb, bit [31:0] u);
            logic [191:0] lhs;
            logic [191:0] rhs;
            longint unsigned cc;
            longint unsigned pc;
            cc = ck * (ck - 1) / 2;
            pc = pk * (pk - 1) / 2;
            lhs = 192'(pk) * 192'(np) + (192'(pc) << 16);
            lhs = lhs * 192'(nc) * 192'(fb) * 192'(u);
            rhs = 192'(ck) * 192'(nc) + (192'(cc) << 16);
            rhs = (rhs * 192'(np) * 192'(fa)) << 32;
            return lhs < rhs;
        endfunction

        function logic [2:0] try_swap(int i, bit [31:0] u);
            int n;
            int m;
            int gi;
            int gj;
            int pi;
            int pj;
            int ck;
            int ng;
            int fa;
            int fb;
            n = leaves;
            m = mutations;
            if (n < 2 || n > MAX_LEAVES || m > MAX_MUTATIONS)
                return ST_INVALID;
            if (i + 1 >= m + n - 1)
                return ST_INVALID;
            gi = ev_geno[i];
            gj = ev_geno[i+1];
            pi = $signed(ev_prod[i]);
            pj = $signed(ev_prod[i+1]);
            if (gi == gj)
                return ST_UNCHANGED;
            if (pi == -1 && pj == -1)
            begin
                swap_pair(i, 0);
                return ST_SWAPPED;
            end
            if (pi != -1 && pj != -1 && pi != gj)
            begin
                swap_pair(i, 1);
                return ST_SWAPPED;
            end
            if (i == m + n - 3)
            begin
                if (rooted)
                    return ST_UNCHANGED;
                if (pj != -1)
                    return ST_INVALID;
                if (pi == -1)
                    return ST_UNCHANGED;
                ng = ev_geno[i];
                ev_geno[i] = ev_geno[i+1];
                ev_geno[i+1] = ng[6:0];
                ev_prod[i] = {1'b0, ev_geno[i+1]};
                return ST_SWAPPED;
            end
            if (pi == gj && ev_glin[i+1] <= 2)
                return ST_UNCHANGED;
            fa = 1;
            fb = 1;
            if (pi == -1 && pj != -1)
            begin
                ck = ev_tlin[i+1];
                ng = ev_glin[i];
                if (ck < 2 || ck > n - 1)
                    return ST_INVALID;
                if (pj == gi)
                begin
                    if (ng < 2)
                        return ST_INVALID;
                    fa = ng + 1;
                    fb = ng - 1;
                end
                if (!ratio_accepts(ck, ck + 1, pop_size[n-ck], pop_size[n-ck-1], fa, fb, u))
                    return ST_REJECTED;
                swap_pair(i, 1);
                if (pj == gi && ev_glin[i+1] < 127)
                    ev_glin[i+1]++;
                ev_tlin[i+1] = 7'(ck + 1);
                return ST_ACCEPTED;
            end
            if (pi != -1 && pj == -1)
            begin
                ck = ev_tlin[i+1];
                ng = ev_glin[i+1];
                if (ck < 3 || ck > n)
                    return ST_INVALID;
                if (pi == gj)
                begin
                    if (ng < 3)
                        return ST_INVALID;
                    fa = ng - 2;
                    fb = ng;
                end
                if (!ratio_accepts(ck, ck - 1, pop_size[n-ck], pop_size[n-ck+1], fa, fb, u))
                    return ST_REJECTED;
                swap_pair(i, 1);
                if (pi == gj)
                    ev_glin[i]--;
                ev_tlin[i+1] = 7'(ck - 1);
                return ST_ACCEPTED;
            end
            return ST_INVALID;
        endfunction

        function void note_input(item_t it);
            outcome_t o;
            int s;
            s = it.slot_index;
            o = '{ST_DONE, 0, 0, 0, 0};
            case (it.kind)
                KIND_WR_EVENT:
                    if (s >= EVENT_DEPTH)
                        o.status = ST_INVALID;
                    else
                    begin
                        ev_geno[s] = it.genotype;
                        ev_prod[s] = it.produced_genotype;
                        ev_glin[s] = it.genotype_lineages;
                        ev_tlin[s] = it.total_lineages;
                    end
                KIND_WR_POP:
                    if (s >= POP_DEPTH || it.population_size == 0)
                        o.status = ST_INVALID;
                    else
                        pop_size[s] = it.population_size;
                KIND_PROPOSE:
                    o.status = try_swap(s, it.uniform_draw);
                default:
                    if (s >= EVENT_DEPTH)
                        o.status = ST_INVALID;
                    else
                    begin
                        o.genotype = ev_geno[s];
                        o.produced = ev_prod[s];
                        o.genotype_lineages = ev_glin[s];
                        o.total_lineages = ev_tlin[s];
                    end
            endcase
            awaited.push_back(o);
        endfunction

        task check_result(outcome_t got);
            outcome_t w;
            if (awaited.size() == 0)
            begin
                report("result beat with nothing awaited");
                return;
            end
            w = awaited.pop_front();
            if (got.status !== w.status)
                report($sformatf("status %0d, want %0d", got.status, w.status));
            if (got.genotype !== w.genotype)
                report($sformatf("genotype %0d, want %0d", got.genotype, w.genotype));
            if (got.produced !== w.produced)
                report($sformatf("produced %0h, want %0h", got.produced, w.produced));
            if (got.genotype_lineages !== w.genotype_lineages)
                report($sformatf("geno lineages %0d, want %0d",
                                 got.genotype_lineages, w.genotype_lineages));
            if (got.total_lineages !== w.total_lineages)
                report($sformatf("total lineages %0d, want %0d",
                                 got.total_lineages, w.total_lineages));
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_write = 0;
    logic [1:0]  cfg_index = 0;
    logic [6:0]  cfg_data = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  kind = 0;
    logic [6:0]  slot_index = 0;
    logic [6:0]  genotype = 0;
    logic signed [7:0] produced_genotype = 0;
    logic [6:0]  genotype_lineages = 0;
    logic [6:0]  total_lineages = 0;
    logic [31:0] population_size = 0;
    logic [31:0] uniform_draw = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [2:0]  status;
    logic [6:0]  read_genotype;
    logic signed [7:0] read_produced;
    logic [6:0]  read_genotype_lineages;
    logic [6:0]  read_total_lineages;

    swap_scoreboard board = new();
    int send_idle_pct = 19;
    int recv_idle_pct = 75;
    int cycles = 0;

    coalescent_event_swap_mh_step uut (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result('{status, read_genotype, read_produced,
                                 read_genotype_lineages, read_total_lineages});

    task send_beat(item_t it);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        kind <= it.kind;
        slot_index <= it.slot_index;
        genotype <= it.genotype;
        produced_genotype <= it.produced_genotype;
        genotype_lineages <= it.genotype_lineages;
        total_lineages <= it.total_lineages;
        population_size <= it.population_size;
        uniform_draw <= it.uniform_draw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_input(it);
    endtask

    task drain;
        @(negedge clk);
        in_valid <= 0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task configure(int n, int m, bit r);
        logic [6:0] vals [3];
        vals = '{7'(n), 7'(m), 7'(r)};
        for (int k = 0; k < 3; k++)
        begin
            @(negedge clk);
            cfg_write <= 1;
            cfg_index <= 2'(k);
            cfg_data <= vals[k];
            board.set_reg(2'(k), vals[k]);
        end
        @(negedge clk);
        cfg_write <= 0;
    endtask

    function item_t make_item(int n, int m, int slot, bit [1:0] k);
        item_t it;
        it.kind = k;
        it.slot_index = 7'(slot);
        it.genotype = 7'($urandom_range(0, 3));
        it.produced_genotype = ($urandom_range(0, 1)) ? 8'hFF : 8'($urandom_range(0, 3));
        it.genotype_lineages = 7'($urandom_range(0, 6));
        it.total_lineages = 7'($urandom_range(0, n + 1));
        it.population_size = 32'h8000 + $urandom_range(0, 32'h3_0000);
        case ($urandom_range(0, 4))
            0: it.uniform_draw = 0;
            1: it.uniform_draw = 32'hFFFF_FFFF;
            default: it.uniform_draw = $urandom;
        endcase
        return it;
    endfunction

    function item_t noise_item();
        item_t it;
        it.kind = 2'($urandom_range(0, 3));
        it.slot_index = 7'($urandom_range(0, 126));
        it.genotype = 7'($urandom_range(0, 64));
        it.produced_genotype = 8'($signed($urandom_range(0, 65)) - 1);
        it.genotype_lineages = 7'($urandom_range(0, 65));
        it.total_lineages = 7'($urandom_range(0, 64));
        it.population_size = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
        it.uniform_draw = $urandom;
        if (it.kind == KIND_WR_POP)
            it.slot_index = 7'($urandom_range(0, 70));
        return it;
    endfunction

    task random_phase(int n, int m, int count);
        item_t it;
        int span;
        int pick;
        span = (m + n - 1 < 2) ? 2 : m + n - 1;
        for (int j = 0; j < count; j++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                it = make_item(n, m, $urandom_range(0, span - 2), KIND_PROPOSE);
            else if (pick < 70)
                it = make_item(n, m, $urandom_range(0, span - 1), KIND_WR_EVENT);
            else if (pick < 78)
                it = make_item(n, m, $urandom_range(0, POP_DEPTH - 1), KIND_WR_POP);
            else if (pick < 88)
                it = make_item(n, m, $urandom_range(0, 126), KIND_RD_EVENT);
            else
                it = noise_item();
            send_beat(it);
        end
    endtask

    initial
    begin
        item_t it;
        int pn [7] = '{2, 64, 8, 5, 1, 65, 12};
        int pm [7] = '{0, 64, 6, 3, 0, 70, 10};
        bit pr [7] = '{1, 0, 0, 1, 1, 0, 0};
        int pc [7] = '{60, 120, 150, 130, 10, 10, 140};
        repeat (10) @(posedge clk);
        rst_n <= 1;
        configure(2, 0, 1);

        for (int s = 0; s < EVENT_DEPTH; s++)
            send_beat(make_item(64, 64, s, KIND_WR_EVENT));
        for (int s = 0; s < POP_DEPTH; s++)
            send_beat(make_item(64, 64, s, KIND_WR_POP));

        it = make_item(2, 0, 0, KIND_RD_EVENT);
        send_beat(it);
        it.slot_index = 126;
        send_beat(it);
        it = make_item(2, 0, 63, KIND_WR_POP);
        send_beat(it);
        it.slot_index = 5;
        it.population_size = 0;
        send_beat(it);
        it.population_size = 32'hFFFF_FFFF;
        send_beat(it);
        it.population_size = 32'd1;
        it.slot_index = 0;
        send_beat(it);
        it = make_item(2, 0, 126, KIND_WR_EVENT);
        it.genotype = 64;
        it.produced_genotype = 64;
        it.genotype_lineages = 65;
        it.total_lineages = 64;
        send_beat(it);
        it.kind = KIND_RD_EVENT;
        send_beat(it);
        for (int j = 0; j < 4; j++)
        begin
            it = make_item(2, 0, j, KIND_PROPOSE);
            it.uniform_draw = j[0] ? 32'hFFFF_FFFF : 32'd0;
            send_beat(it);
        end
        drain();

        for (int p = 0; p < 7; p++)
        begin
            if (p == 3)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 19;
            end
            else if (p == 5)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            configure(pn[p], pm[p], pr[p]);
            random_phase(pn[p], pm[p], pc[p]);
            drain();
        end

        if (board.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
